/* hdl/ofmt_pkg.sv */
`default_nettype none

package ofmt_pkg;

  // ASCII codes used in the field
  localparam logic [7:0] DigitZero = 8'd48;
  localparam logic [7:0] PadSpace  = 8'd32;

  // Octal digits held for a 64-bit value (22 digits, 66 bits)
  localparam int unsigned NumDigits = 22;
  localparam int unsigned DigBits   = 3 * NumDigits;

  // Size mode codes; any other code keeps 32 bits
  localparam logic [1:0] SizeKeep64 = 2'd1;
  localparam logic [1:0] SizeKeep16 = 2'd2;

  // Flag bit positions
  localparam int unsigned FlagLeft = 0;
  localparam int unsigned FlagZero = 1;
  localparam int unsigned FlagAlt  = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_PRE,
    ST_ZERO,
    ST_DIGIT,
    ST_POST
  } state_e;

  // Source of the character being emitted
  typedef enum logic [1:0] {
    SRC_PAD,
    SRC_ZERO,
    SRC_DIGIT
  } src_e;

  typedef struct packed {
    logic load;
    logic scan_shift;
    logic calc;
    logic emit;
    src_e src;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic suppress;
    logic left;
    logic pads_zero;
    logic zeros_zero;
    logic digits_zero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* hdl/ofmt_in_if.sv */
`default_nettype none

interface ofmt_in_if;
  logic               valid;
  logic               ready;
  logic        [63:0] value;
  logic        [1:0]  size_mode;
  logic        [2:0]  flags;
  logic        [5:0]  field_width;
  logic signed [6:0]  precision;

  modport source (
    output valid, value, size_mode, flags, field_width, precision,
    input  ready
  );

  modport sink (
    input  valid, value, size_mode, flags, field_width, precision,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/ofmt_out_if.sv */
`default_nettype none

interface ofmt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (
    output valid, char_out, last,
    input  ready
  );

  modport sink (
    input  valid, char_out, last,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/octal_field_formatter_unit.sv */
`default_nettype none

// Octal field formatter. Each input item holds a value, a size mode, flags,
// a field width and a precision; the unit sends the formatted octal field as
// one output item per character, with last set on the final one. An item
// whose value (after truncation) is zero with precision zero and no
// alternate-form prefix produces no output items. Input is taken only when
// the unit is idle; a new item can be accepted while the last character of
// the previous one still waits at the output. One item passes through a load
// step, a leading-digit scan (up to 21 leading zero digits shifted out one per
// cycle, fewer for values with more significant digits, then a step that finds
// the leading digit), a sizing step, then one character per cycle while the
// output is free, with a phase change between padding, zeros and digits; the
// field holds up to MAX_FIELD characters.
// There is no reset-time initialisation pass.
module octal_field_formatter_unit
  import ofmt_pkg::*;
#(
  parameter int unsigned MAX_FIELD = 63
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ofmt_in_if.sink     in_i,
  ofmt_out_if.source  out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;
  logic [7:0] char_out;
  logic    last;

  // Sequencer
  ofmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Digit store, counters and output register
  ofmt_dpath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (in_i.value),
    .size_mode_i   (in_i.size_mode),
    .flags_i       (in_i.flags),
    .field_width_i (in_i.field_width),
    .precision_i   (in_i.precision),
    .cmd_i         (cmd),
    .status_o      (status),
    .valid_o       (out_valid),
    .ready_i       (out_o.ready),
    .char_out_o    (char_out),
    .last_o        (last)
  );

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid;
  assign out_o.char_out = char_out;
  assign out_o.last     = last;

endmodule

`default_nettype wire

/* hdl/ofmt_ctrl.sv */
`default_nettype none

module ofmt_ctrl
  import ofmt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.src      = SRC_PAD;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_CALC;
        end else begin
          cmd_o.scan_shift = 1'b1;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        if (status_i.suppress) begin
          state_d = ST_IDLE;
        end else if (status_i.left) begin
          state_d = ST_ZERO;
        end else begin
          state_d = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd_o.src = SRC_PAD;
        if (status_i.pads_zero) begin
          state_d = ST_ZERO;
        end else begin
          cmd_o.emit = status_i.out_free;
        end
      end
      ST_ZERO: begin
        cmd_o.src = SRC_ZERO;
        if (status_i.zeros_zero) begin
          state_d = ST_DIGIT;
        end else begin
          cmd_o.emit = status_i.out_free;
        end
      end
      ST_DIGIT: begin
        cmd_o.src = SRC_DIGIT;
        if (status_i.digits_zero) begin
          state_d = status_i.left ? ST_POST : ST_IDLE;
        end else begin
          cmd_o.emit = status_i.out_free;
        end
      end
      ST_POST: begin
        cmd_o.src = SRC_PAD;
        if (status_i.pads_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.emit = status_i.out_free;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/ofmt_dpath.sv */
`default_nettype none

module ofmt_dpath
  import ofmt_pkg::*;
#(
  parameter int unsigned MAX_FIELD = 63
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic        [63:0] value_i,
  input  wire logic        [1:0]  size_mode_i,
  input  wire logic        [2:0]  flags_i,
  input  wire logic        [5:0]  field_width_i,
  input  wire logic signed [6:0]  precision_i,
  input  wire cmd_t               cmd_i,
  output status_t                 status_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic             [7:0]  char_out_o,
  output logic                    last_o
);

  localparam logic [5:0] MaxField = 6'(MAX_FIELD);
  localparam logic [4:0] NdigInit = 5'(NumDigits);

  // Item registers
  logic [DigBits-1:0] dig_q, dig_d;
  logic [4:0]         ndig_q, ndig_d;
  logic               orig_nz_q;
  logic [2:0]         flags_q;
  logic [5:0]         width_q;
  logic [6:0]         prec_q;
  logic [5:0]         zeros_q, zeros_d;
  logic [5:0]         pads_q, pads_d;
  logic [5:0]         rem_q, rem_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [7:0]         char_q, char_d;
  logic               last_q, last_d;

  logic [63:0] num;
  logic [2:0]  top_digit;
  logic        prefix;
  logic        prec_given;
  logic [5:0]  prec_sat, prec_eff, wid_sat;
  logic [5:0]  nrev, len, pads_calc;
  logic        out_free;
  logic [7:0]  pad_char;

  // Truncation by size mode
  always_comb begin
    case (size_mode_i)
      SizeKeep64: num = value_i;
      SizeKeep16: num = {48'd0, value_i[15:0]};
      default:    num = {32'd0, value_i[31:0]};
    endcase
  end

  assign top_digit  = dig_q[DigBits-1 -: 3];
  assign prefix     = flags_q[FlagAlt] & orig_nz_q;
  assign prec_given = !prec_q[6];
  assign prec_sat   = (prec_q[5:0] > MaxField) ? MaxField : prec_q[5:0];
  assign prec_eff   = prec_given ? prec_sat : 6'd0;
  assign wid_sat    = (width_q > MaxField) ? MaxField : width_q;
  assign nrev       = {1'b0, ndig_q} + {5'd0, prefix};
  assign len        = (prec_eff > nrev) ? prec_eff : nrev;
  assign pads_calc  = (wid_sat > len) ? (wid_sat - len) : 6'd0;
  assign out_free   = !out_valid_q || ready_i;
  assign pad_char   = (flags_q[FlagZero] && !flags_q[FlagLeft]) ? DigitZero : PadSpace;

  // Item registers: load, digit scan, field sizing, emission
  always_comb begin
    dig_d   = dig_q;
    ndig_d  = ndig_q;
    zeros_d = zeros_q;
    pads_d  = pads_q;
    rem_d   = rem_q;
    if (cmd_i.load) begin
      dig_d  = {2'b00, num};
      ndig_d = NdigInit;
    end else if (cmd_i.scan_shift) begin
      dig_d  = {dig_q[DigBits-4:0], 3'b000};
      ndig_d = ndig_q - 5'd1;
    end else if (cmd_i.calc) begin
      zeros_d = len - {1'b0, ndig_q};
      pads_d  = pads_calc;
      rem_d   = len + pads_calc;
    end else if (cmd_i.emit) begin
      rem_d = rem_q - 6'd1;
      case (cmd_i.src)
        SRC_PAD:  pads_d  = pads_q - 6'd1;
        SRC_ZERO: zeros_d = zeros_q - 6'd1;
        default: begin
          dig_d  = {dig_q[DigBits-4:0], 3'b000};
          ndig_d = ndig_q - 5'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
    if (cmd_i.load) begin
      orig_nz_q <= |value_i;
      flags_q   <= flags_i;
      width_q   <= field_width_i;
      prec_q    <= precision_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndig_q  <= '0;
      zeros_q <= '0;
      pads_q  <= '0;
      rem_q   <= '0;
    end else begin
      ndig_q  <= ndig_d;
      zeros_q <= zeros_d;
      pads_q  <= pads_d;
      rem_q   <= rem_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      last_d      = (rem_q == 6'd1);
      case (cmd_i.src)
        SRC_PAD:  char_d = pad_char;
        SRC_ZERO: char_d = DigitZero;
        default:  char_d = DigitZero + {5'd0, top_digit};
      endcase
    end else if (ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Status to the controller
  always_comb begin
    status_o             = '0;
    status_o.scan_done   = (top_digit != 3'd0) || (ndig_q == 5'd1);
    status_o.suppress    = (top_digit == 3'd0) && (ndig_q == 5'd1) && !prefix
                           && prec_given && (prec_q[5:0] == 6'd0);
    status_o.left        = flags_q[FlagLeft];
    status_o.pads_zero   = (pads_q == 6'd0);
    status_o.zeros_zero  = (zeros_q == 6'd0);
    status_o.digits_zero = (ndig_q == 5'd0);
    status_o.out_free    = out_free;
  end

  assign valid_o    = out_valid_q;
  assign char_out_o = char_q;
  assign last_o     = last_q;

  // A held item is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("ofmt: emit while output item stalled");

  // Every emitted item is counted in the remaining total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (rem_q != 6'd0))
    else $error("ofmt: emit beyond field length");

  // Digits only come out while some remain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (cmd_i.src == SRC_DIGIT)) |-> (ndig_q != 5'd0))
    else $error("ofmt: digit emitted with none left");

  // The final item of a field leaves nothing to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (rem_q == 6'd1)) |=> (rem_q == 6'd0) && last_q)
    else $error("ofmt: last flag out of step with count");

endmodule

`default_nettype wire
